### rtl/cgs_pkg.sv
// ---------------------------------------------------------------------------
// cgs_pkg
// shared constants and types for the circular gaussian smoother
// ---------------------------------------------------------------------------
package cgs_pkg;

    localparam int DATA_W          = 16;
    localparam int COEF_W          = 16;
    localparam int IDX_W           = 12;
    localparam int SC_W            = 13;
    localparam int TAPS            = 13;
    localparam int HALF            = 6;
    localparam int HEAD            = 12;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int MIN_SAMPLES     = 13;
    localparam int SC_RESET        = 4096;

    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_COEF_CENTER  = 3'd0;
    localparam logic [2:0] REG_COEF_OFF1    = 3'd1;
    localparam logic [2:0] REG_COEF_OFF2    = 3'd2;
    localparam logic [2:0] REG_COEF_OFF3    = 3'd3;
    localparam logic [2:0] REG_COEF_OFF4    = 3'd4;
    localparam logic [2:0] REG_COEF_OFF5    = 3'd5;
    localparam logic [2:0] REG_COEF_OFF6    = 3'd6;
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd7;

    typedef logic [TAPS-1:0][DATA_W-1:0] t_window;
    typedef logic [HALF:0][COEF_W-1:0]   t_coefs;

    typedef struct packed {
        t_window          smp;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_job;

endpackage

### rtl/cgs_filter.sv
// ---------------------------------------------------------------------------
// cgs_filter
// symmetric 13-tap filter pipeline: pre-add and multiply, sum, round and
// saturate into the output register
// ---------------------------------------------------------------------------
module cgs_filter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_valid,
    input  cgs_pkg::t_job                    i_job,
    output logic                             o_job_ready,
    input  cgs_pkg::t_coefs                  i_coef,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [cgs_pkg::DATA_W-1:0] o_smoothed_height,
    output logic [cgs_pkg::IDX_W-1:0]        o_sample_index,
    output logic                             o_last
);

    localparam int PAIR_W  = cgs_pkg::DATA_W + 1;
    localparam int PROD_W  = PAIR_W + cgs_pkg::COEF_W + 1;
    localparam int ACC_W   = PROD_W + 3;
    localparam int FRAC_W  = cgs_pkg::COEF_W;
    localparam int RND_W   = ACC_W - FRAC_W;
    localparam int SAT_MAX = (1 << (cgs_pkg::DATA_W - 1)) - 1;
    localparam int SAT_MIN = -(1 << (cgs_pkg::DATA_W - 1));
    localparam int NP      = cgs_pkg::HALF + 1;

    logic                       out_ready;
    logic                       s2_ready;
    logic                       s1_ready;

    logic signed [PAIR_W-1:0]   pair   [NP];
    logic signed [PROD_W-1:0]   n_prod [NP];
    logic signed [PROD_W-1:0]   r_prod [NP];
    logic [cgs_pkg::IDX_W-1:0]  r_s1_idx;
    logic                       r_s1_last;
    logic                       r_s1_valid;

    logic signed [ACC_W-1:0]    n_sum;
    logic signed [ACC_W-1:0]    r_sum;
    logic [cgs_pkg::IDX_W-1:0]  r_s2_idx;
    logic                       r_s2_last;
    logic                       r_s2_valid;

    logic signed [ACC_W-1:0]    biased;
    logic signed [RND_W-1:0]    rnd;
    logic signed [cgs_pkg::DATA_W-1:0] n_sat;

    logic                       r_out_valid;
    logic signed [cgs_pkg::DATA_W-1:0] r_out_h;
    logic [cgs_pkg::IDX_W-1:0]  r_out_idx;
    logic                       r_out_last;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign s2_ready    = !r_s2_valid || out_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign o_job_ready = s1_ready;

    // fold mirrored taps before the multiply
    always_comb begin
        for (int k = 0; k < NP; k++) begin
            if (k == 0) begin
                pair[k] = PAIR_W'($signed(i_job.smp[cgs_pkg::HALF]));
            end else begin
                pair[k] = PAIR_W'($signed(i_job.smp[cgs_pkg::HALF - k]))
                        + PAIR_W'($signed(i_job.smp[cgs_pkg::HALF + k]));
            end
            n_prod[k] = PROD_W'(pair[k] * $signed({1'b0, i_coef[k]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_job_valid;
        end
        if (s1_ready && i_job_valid) begin
            r_prod    <= n_prod;
            r_s1_idx  <= i_job.idx;
            r_s1_last <= i_job.last;
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < NP; k++) begin
            n_sum = n_sum + ACC_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_ready && r_s1_valid) begin
            r_sum     <= n_sum;
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;
        end
    end

    // round half up, then clamp to the output range
    always_comb begin
        biased = r_sum + ACC_W'(1 << (FRAC_W - 1));
        rnd    = biased[ACC_W-1:FRAC_W];
        if (rnd > RND_W'(SAT_MAX)) begin
            n_sat = cgs_pkg::DATA_W'(SAT_MAX);
        end else if (rnd < RND_W'(SAT_MIN)) begin
            n_sat = cgs_pkg::DATA_W'(SAT_MIN);
        end else begin
            n_sat = rnd[cgs_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s2_valid;
        end
        if (out_ready && r_s2_valid) begin
            r_out_h    <= n_sat;
            r_out_idx  <= r_s2_idx;
            r_out_last <= r_s2_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_smoothed_height = r_out_h;
    assign o_sample_index    = r_out_idx;
    assign o_last            = r_out_last;

endmodule

### rtl/circular_gaussian_smoother.sv
// ---------------------------------------------------------------------------
// circular_gaussian_smoother
// path: job register, then the filter's product, sum and output registers
// throughput: one sample per cycle while the output does not stall; after the
// last sample of a set, input stalls while the twelve wrap-around words go out
// reset: control state cleared, weights zero, sample count 4096, no clearing
// pass; sample stores hold garbage until written
// ---------------------------------------------------------------------------
module circular_gaussian_smoother #(
    parameter int MAX_SAMPLES = cgs_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [cgs_pkg::DATA_W-1:0]  i_height_sample,

    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [cgs_pkg::DATA_W-1:0]  o_smoothed_height,
    output logic [cgs_pkg::IDX_W-1:0]          o_sample_index,
    output logic                               o_last,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cgs_pkg::APB_AW-1:0]         paddr,
    input  logic [cgs_pkg::APB_DW-1:0]         pwdata,
    output logic [cgs_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES);
    localparam int N_W    = CNT_W + 1;
    localparam int TAIL_N = 2 * cgs_pkg::HEAD;
    localparam int T_W    = $clog2(cgs_pkg::HEAD);
    localparam int DW     = cgs_pkg::DATA_W;

    // configuration
    logic [2:0]                 reg_sel;
    logic                       cfg_wr;
    cgs_pkg::t_coefs            r_coef;
    logic [cgs_pkg::SC_W-1:0]   r_sample_count;

    assign pready  = 1'b1;
    assign reg_sel = paddr[cgs_pkg::APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef         <= '0;
            r_sample_count <= cgs_pkg::SC_W'(cgs_pkg::SC_RESET);
        end else if (cfg_wr) begin
            case (reg_sel)
                cgs_pkg::REG_SAMPLE_COUNT: r_sample_count <= pwdata[cgs_pkg::SC_W-1:0];
                default: r_coef[reg_sel] <= pwdata[cgs_pkg::COEF_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            cgs_pkg::REG_SAMPLE_COUNT:
                prdata = cgs_pkg::APB_DW'(r_sample_count);
            default:
                prdata = cgs_pkg::APB_DW'(r_coef[reg_sel]);
        endcase
    end

    // effective profile length
    logic [31:0]       n32;
    logic [N_W-1:0]    n_eff;

    always_comb begin
        n32 = 32'(r_sample_count);
        if (n32 < 32'(cgs_pkg::MIN_SAMPLES)) begin
            n32 = 32'(cgs_pkg::MIN_SAMPLES);
        end else if (n32 > 32'(MAX_SAMPLES)) begin
            n32 = 32'(MAX_SAMPLES);
        end
        n_eff = n32[N_W-1:0];
    end

    // sample intake
    logic                       in_acc;
    logic                       is_last;
    logic                       job_ready;
    logic                       filt_ready;
    logic                       tail_fire;
    logic [31:0]                idx32;
    logic [31:0]                base32;
    logic [cgs_pkg::IDX_W-1:0]  tail_idx;
    cgs_pkg::t_window           win_n;

    logic [CNT_W-1:0]           r_cnt;
    cgs_pkg::t_window           r_win;
    logic [DW-1:0]              r_head [cgs_pkg::HEAD];
    logic [DW-1:0]              r_tail [TAIL_N];
    logic [cgs_pkg::IDX_W-1:0]  r_tail_base;
    logic [T_W-1:0]             r_tail_t;
    logic                       r_tail_busy;
    cgs_pkg::t_job              r_job;
    logic                       r_job_valid;

    assign job_ready  = !r_job_valid || filt_ready;
    assign o_in_stall = r_tail_busy || !job_ready;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign tail_fire  = r_tail_busy && job_ready;
    assign is_last    = N_W'(r_cnt) >= (n_eff - N_W'(1));
    assign idx32      = 32'(r_cnt) - 32'(cgs_pkg::HALF);
    assign base32     = 32'(n_eff) - 32'(cgs_pkg::HALF);

    always_comb begin
        for (int k = 0; k < cgs_pkg::TAPS - 1; k++) begin
            win_n[k] = r_win[k + 1];
        end
        win_n[cgs_pkg::TAPS-1] = i_height_sample;
    end

    always_comb begin
        if (32'(r_tail_t) < 32'(cgs_pkg::HALF)) begin
            tail_idx = r_tail_base + cgs_pkg::IDX_W'(r_tail_t);
        end else begin
            tail_idx = cgs_pkg::IDX_W'(r_tail_t) - cgs_pkg::IDX_W'(cgs_pkg::HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_tail_busy <= 1'b0;
            r_tail_t    <= '0;
            r_job_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cnt <= is_last ? '0 : r_cnt + CNT_W'(1);
            end
            if (in_acc && is_last) begin
                r_tail_busy <= 1'b1;
                r_tail_t    <= '0;
            end else if (tail_fire) begin
                r_tail_t <= r_tail_t + T_W'(1);
                if (32'(r_tail_t) == 32'(cgs_pkg::HEAD - 1)) begin
                    r_tail_busy <= 1'b0;
                end
            end
            if (in_acc && 32'(r_cnt) >= 32'(cgs_pkg::HEAD)) begin
                r_job_valid <= 1'b1;
            end else if (tail_fire) begin
                r_job_valid <= 1'b1;
            end else if (job_ready) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    // sample stores and job payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_win <= win_n;
            if (32'(r_cnt) < 32'(cgs_pkg::HEAD)) begin
                r_head[r_cnt[T_W-1:0]] <= i_height_sample;
            end
        end
        if (in_acc && is_last) begin
            for (int k = 0; k < cgs_pkg::HEAD; k++) begin
                r_tail[k]                <= win_n[k + 1];
                r_tail[cgs_pkg::HEAD + k] <= r_head[k];
            end
            r_tail_base <= base32[cgs_pkg::IDX_W-1:0];
        end else if (tail_fire) begin
            for (int k = 0; k < TAIL_N - 1; k++) begin
                r_tail[k] <= r_tail[k + 1];
            end
        end
        if (in_acc) begin
            r_job.smp  <= win_n;
            r_job.idx  <= idx32[cgs_pkg::IDX_W-1:0];
            r_job.last <= 1'b0;
        end else if (tail_fire) begin
            for (int k = 0; k < cgs_pkg::TAPS; k++) begin
                r_job.smp[k] <= r_tail[k];
            end
            r_job.idx  <= tail_idx;
            r_job.last <= (32'(r_tail_t) == 32'(cgs_pkg::HEAD - 1));
        end
    end

    cgs_filter u_filter (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_job_valid       (r_job_valid),
        .i_job             (r_job),
        .o_job_ready       (filt_ready),
        .i_coef            (r_coef),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_smoothed_height (o_smoothed_height),
        .o_sample_index    (o_sample_index),
        .o_last            (o_last)
    );

    // wrap-around outputs block new samples
    a_tail_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_busy |-> o_in_stall)
        else $error("sample accepted during wrap-around outputs");

    a_last_starts_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_last) |=> r_tail_busy)
        else $error("last sample did not start wrap-around outputs");

    a_tail_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_tail_busy) && !r_tail_busy) |->
            (32'($past(r_tail_t)) == 32'(cgs_pkg::HEAD - 1)))
        else $error("wrap-around ended before twelve words");

endmodule
